>>> design/double_to_minifloat_rounding_core_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the minifloat rounding core
// Shorthand for clocked implication checks with reset disable.
// ---------------------------------------------------------------------------
`ifndef DOUBLE_TO_MINIFLOAT_ROUNDING_CORE_ASSERT_SVH
`define DOUBLE_TO_MINIFLOAT_ROUNDING_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DTMF_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dtmf same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define DTMF_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dtmf next-cycle check failed");

`endif

>>> design/dtmf_pkg.sv
// ---------------------------------------------------------------------------
// dtmf_pkg
// Constants and types shared by the minifloat rounding core.
// ---------------------------------------------------------------------------
package dtmf_pkg;

	typedef enum logic {
		REG_EXPONENT_WIDTH = 1'b0,
		REG_MANTISSA_WIDTH = 1'b1
	} cfg_reg_t;

	localparam logic [10:0] EXP_ALL_ONES = 11'h7FF;
	localparam logic signed [11:0] EXP_BIAS = 12'sd1023;
	localparam logic [19:0] SMALL_FRAC_MASK = 20'hFFFFF;

	localparam logic [3:0] EW_RESET = 4'd8;
	localparam logic [4:0] MW_RESET = 5'd23;

	localparam logic [10:0] SP_MAX_FIELD = 11'd1150;
	localparam logic [10:0] SP_MIN_NORM_FIELD = 11'd897;
	localparam logic [10:0] SP_MIN_KEEP_FIELD = 11'd873;
	localparam logic [5:0] SP_BASE_DROP = 6'd29;
	localparam logic signed [11:0] SP_MAX_EXP = 12'sd127;

endpackage

>>> design/dtmf_lead_one.sv
// ---------------------------------------------------------------------------
// dtmf_lead_one
// Priority encoder giving the position of the most significant set bit.
// ---------------------------------------------------------------------------
module dtmf_lead_one #(
	parameter int W = 25
) (
	input  logic [W-1:0]         vec,
	output logic [$clog2(W)-1:0] pos
);

	always_comb begin
		pos = '0;
		for (int i = 1; i < W; i++) begin
			if (vec[i]) begin
				pos = ($clog2(W))'(i);
			end
		end
	end

endmodule

>>> design/double_to_minifloat_rounding_core.sv
// ---------------------------------------------------------------------------
// double_to_minifloat_rounding_core
// Quantizes binary64 values to a configurable small float format.
// ---------------------------------------------------------------------------
// Input beats arrive on s_tvalid/s_tready/s_tdata, one binary64 pattern each.
// Results leave on m_tvalid/m_tready/m_tdata with m_tuser set when the
// configured widths are unsupported, in which case the data is zero.
// The format registers are written over cfg_valid/cfg_index/cfg_data, which
// is always ready; write them only while no beat is in flight.
// The datapath is three register stages: decode and first rounding, range
// handling and second rounding, then leading-one normalization into the
// output register. A new beat can enter every cycle while s_tready is high,
// so throughput is one beat per cycle while the receiver keeps up.
// When the receiver stalls, each stage holds its beat and s_tready falls
// only once all three stages are full; nothing is dropped or repeated.
// Reset empties the pipeline and loads exponent width 8 and mantissa
// width 23, which selects IEEE single precision with ties to even.
// ---------------------------------------------------------------------------
module double_to_minifloat_rounding_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // value_bits
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // rounded_bits
	output logic        m_tuser,   // format_error
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [4:0]  cfg_data
);

	logic [3:0] ew_q;
	logic [4:0] mw_q;

	logic en1, en2, en3;
	logic v_s1, v_s2;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ew_q <= dtmf_pkg::EW_RESET;
			mw_q <= dtmf_pkg::MW_RESET;
		end else if (cfg_valid) begin
			unique case (dtmf_pkg::cfg_reg_t'(cfg_index))
				dtmf_pkg::REG_EXPONENT_WIDTH: ew_q <= cfg_data[3:0];
				dtmf_pkg::REG_MANTISSA_WIDTH: mw_q <= cfg_data;
			endcase
		end
	end

	assign en3 = !m_tvalid || m_tready;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign s_tready = en1;

	// Stage 1: classification, single precision alignment, small-format rounding.
	logic [10:0] e_in;
	logic [51:0] f_in;
	logic sign_in;
	logic signed [11:0] ex_in;
	logic single_in, err_in, zero_in;
	logic spfix_in;
	logic [63:0] spfix_val_in;
	logic [5:0] drop_in;
	logic [10:0] extra_in;
	logic [52:0] sig_in, shifted_in;
	logic guard_in, sticky_in, sp_rnd_in;
	logic signed [11:0] sp_lsb_in;
	logic signed [11:0] max_exp_in, min_exp_in, min_sub_in;
	logic [19:0] frac20_in, mant0_in, rvec_in;
	logic [20:0] mant1_in, max_mant_in;
	logic signed [11:0] sm_expo_in;
	logic [19:0] sm_mant_in;

	always_comb begin
		e_in = s_tdata[62:52];
		f_in = s_tdata[51:0];
		sign_in = s_tdata[63];
		ex_in = $signed({1'b0, e_in}) - dtmf_pkg::EXP_BIAS;
		single_in = (ew_q == 4'd8) && (mw_q == 5'd23);
		err_in = !(single_in || (ew_q >= 4'd2 && ew_q <= 4'd8 && mw_q <= 5'd19));
		zero_in = (s_tdata[62:0] == 63'd0);

		spfix_in = 1'b1;
		spfix_val_in = {sign_in, 63'd0};
		if (e_in == dtmf_pkg::EXP_ALL_ONES) begin
			if (f_in == 52'd0) begin
				spfix_val_in = {sign_in, dtmf_pkg::EXP_ALL_ONES, 52'd0};
			end else begin
				spfix_val_in = {sign_in, dtmf_pkg::EXP_ALL_ONES, 1'b1, f_in[50:29], 29'd0};
			end
		end else if (e_in == 11'd0) begin
			spfix_val_in = {sign_in, 63'd0};
		end else if (e_in > dtmf_pkg::SP_MAX_FIELD) begin
			spfix_val_in = {sign_in, dtmf_pkg::EXP_ALL_ONES, 52'd0};
		end else if (e_in < dtmf_pkg::SP_MIN_KEEP_FIELD) begin
			spfix_val_in = {sign_in, 63'd0};
		end else begin
			spfix_in = 1'b0;
		end

		extra_in = dtmf_pkg::SP_MIN_NORM_FIELD - e_in;
		if (e_in < dtmf_pkg::SP_MIN_NORM_FIELD) begin
			drop_in = dtmf_pkg::SP_BASE_DROP + {1'b0, extra_in[4:0]};
		end else begin
			drop_in = dtmf_pkg::SP_BASE_DROP;
		end
		sig_in = {1'b1, f_in};
		shifted_in = sig_in >> drop_in;
		guard_in = sig_in[drop_in - 6'd1];
		sticky_in = |(sig_in & ((53'd1 << (drop_in - 6'd1)) - 53'd1));
		sp_rnd_in = guard_in && (sticky_in || shifted_in[0]);
		sp_lsb_in = ex_in - 12'sd52 + $signed({6'd0, drop_in});

		max_exp_in = $signed(12'd1 << (ew_q - 4'd1)) - 12'sd1;
		min_exp_in = 12'sd1 - max_exp_in;
		min_sub_in = min_exp_in - $signed({7'd0, mw_q});

		frac20_in = s_tdata[51:32] & dtmf_pkg::SMALL_FRAC_MASK;
		mant0_in = frac20_in >> (5'd20 - mw_q);
		rvec_in = frac20_in >> (5'd19 - mw_q);
		mant1_in = {1'b0, mant0_in} + {20'd0, rvec_in[0]};
		max_mant_in = (21'd1 << mw_q) - 21'd1;
		if (mant1_in > max_mant_in) begin
			sm_mant_in = 20'd0;
			sm_expo_in = ex_in + 12'sd1;
		end else begin
			sm_mant_in = mant1_in[19:0];
			sm_expo_in = ex_in;
		end
	end

	logic err_s1, zero_s1, single_s1, sign_s1;
	logic spfix_s1, sp_rnd_s1, sm_fnz_s1;
	logic [63:0] spfix_val_s1;
	logic [23:0] sp_q_s1;
	logic signed [11:0] sp_lsb_s1, sm_expo_s1, sm_orig_s1;
	logic signed [11:0] max_exp_s1, min_exp_s1, min_sub_s1;
	logic [19:0] sm_mant_s1;
	logic [4:0] mw_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en1) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			err_s1 <= err_in;
			zero_s1 <= zero_in;
			single_s1 <= single_in;
			sign_s1 <= sign_in;
			spfix_s1 <= spfix_in;
			spfix_val_s1 <= spfix_val_in;
			sp_q_s1 <= shifted_in[23:0];
			sp_rnd_s1 <= sp_rnd_in;
			sp_lsb_s1 <= sp_lsb_in;
			sm_expo_s1 <= sm_expo_in;
			sm_orig_s1 <= ex_in;
			sm_mant_s1 <= sm_mant_in;
			sm_fnz_s1 <= (f_in != 52'd0);
			max_exp_s1 <= max_exp_in;
			min_exp_s1 <= min_exp_in;
			min_sub_s1 <= min_sub_in;
			mw_s1 <= mw_q;
		end
	end

	// Stage 2: single precision increment, small-format range handling.
	logic [24:0] sp_q2_mid;
	logic signed [11:0] sm_expo_mid, min_sub_m1_mid;
	logic [19:0] sm_mant_mid, shvec_mid, max_mant_mid;
	logic [20:0] sm_m2_mid;
	logic sm_renorm_mid, above_mid;
	logic [4:0] shift_mid;
	logic signed [11:0] shift_wide_mid;

	always_comb begin
		sp_q2_mid = {1'b0, sp_q_s1} + {24'd0, sp_rnd_s1};
		sm_expo_mid = sm_expo_s1;
		sm_mant_mid = sm_mant_s1;
		sm_m2_mid = 21'd0;
		sm_renorm_mid = 1'b0;
		max_mant_mid = (20'd1 << mw_s1) - 20'd1;
		min_sub_m1_mid = min_sub_s1 - 12'sd1;
		above_mid = !sign_s1 && ((sm_orig_s1 > min_sub_m1_mid) ||
			(sm_orig_s1 == min_sub_m1_mid && sm_fnz_s1));
		shift_wide_mid = min_exp_s1 - sm_expo_s1;
		shift_mid = shift_wide_mid[4:0];
		shvec_mid = sm_mant_s1 >> (shift_mid - 5'd1);
		if (sm_expo_s1 > max_exp_s1) begin
			sm_expo_mid = max_exp_s1;
			sm_mant_mid = max_mant_mid;
		end else if (sm_expo_s1 < min_sub_s1) begin
			sm_expo_mid = above_mid ? min_sub_s1 : -dtmf_pkg::EXP_BIAS;
			sm_mant_mid = 20'd0;
		end else if (sm_expo_s1 < min_exp_s1) begin
			if (shvec_mid[0]) begin
				sm_renorm_mid = 1'b1;
				sm_m2_mid = (({1'b0, sm_mant_s1} | (21'd1 << mw_s1)) >> shift_mid) + 21'd1;
			end else begin
				sm_mant_mid = sm_mant_s1 & ~((20'd1 << shift_mid) - 20'd1);
			end
		end
	end

	logic err_s2, zero_s2, single_s2, sign_s2, spfix_s2, sm_renorm_s2;
	logic [63:0] spfix_val_s2;
	logic [24:0] sp_q2_s2;
	logic signed [11:0] sp_lsb_s2, sm_expo_s2, min_sub_s2;
	logic [19:0] sm_mant_s2;
	logic [20:0] sm_m2_s2;
	logic [4:0] mw_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			err_s2 <= err_s1;
			zero_s2 <= zero_s1;
			single_s2 <= single_s1;
			sign_s2 <= sign_s1;
			spfix_s2 <= spfix_s1;
			spfix_val_s2 <= spfix_val_s1;
			sp_q2_s2 <= sp_q2_mid;
			sp_lsb_s2 <= sp_lsb_s1;
			sm_expo_s2 <= sm_expo_mid;
			sm_mant_s2 <= sm_mant_mid;
			sm_m2_s2 <= sm_m2_mid;
			sm_renorm_s2 <= sm_renorm_mid;
			min_sub_s2 <= min_sub_s1;
			mw_s2 <= mw_s1;
		end
	end

	// Stage 3: normalization and result assembly.
	logic [4:0] sp_p, sm_p;
	logic signed [11:0] sp_top_exp, sp_field, sm_expo_fin, sm_field;
	logic [52:0] sp_norm;
	logic [63:0] sp_res, res_fin;
	logic [19:0] sm_mant_fin;
	logic [20:0] sm_norm;
	logic [31:0] sm_upper;

	dtmf_lead_one #(.W(25)) u_sp_lead (
		.vec (sp_q2_s2),
		.pos (sp_p)
	);

	dtmf_lead_one #(.W(21)) u_sm_lead (
		.vec (sm_m2_s2),
		.pos (sm_p)
	);

	always_comb begin
		sp_top_exp = sp_lsb_s2 + $signed({7'd0, sp_p});
		sp_field = sp_top_exp + dtmf_pkg::EXP_BIAS;
		sp_norm = {28'd0, sp_q2_s2} << (6'd52 - {1'b0, sp_p});
		if (spfix_s2) begin
			sp_res = spfix_val_s2;
		end else if (sp_q2_s2 == 25'd0) begin
			sp_res = {sign_s2, 63'd0};
		end else if (sp_top_exp > dtmf_pkg::SP_MAX_EXP) begin
			sp_res = {sign_s2, dtmf_pkg::EXP_ALL_ONES, 52'd0};
		end else begin
			sp_res = {sign_s2, sp_field[10:0], sp_norm[51:0]};
		end

		sm_norm = sm_m2_s2 << (mw_s2 - sm_p);
		if (sm_renorm_s2) begin
			sm_expo_fin = min_sub_s2 + $signed({7'd0, sm_p});
			sm_mant_fin = sm_norm[19:0] & ((20'd1 << mw_s2) - 20'd1);
		end else begin
			sm_expo_fin = sm_expo_s2;
			sm_mant_fin = sm_mant_s2;
		end
		sm_field = sm_expo_fin + dtmf_pkg::EXP_BIAS;
		sm_upper = {sign_s2, sm_field[10:0], sm_mant_fin << (5'd20 - mw_s2)};

		if (err_s2 || zero_s2) begin
			res_fin = 64'd0;
		end else if (single_s2) begin
			res_fin = sp_res;
		end else begin
			res_fin = {sm_upper, 32'd0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (en3) begin
			m_tvalid <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			m_tdata <= res_fin;
			m_tuser <= err_s2;
		end
	end

endmodule

>>> design/dtmf_checker.sv
// ---------------------------------------------------------------------------
// dtmf_checker
// Port-level checks for the minifloat rounding core, bound to the top level.
// ---------------------------------------------------------------------------
`include "double_to_minifloat_rounding_core_assert.svh"

module dtmf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata,
	input logic        m_tuser
);

	`DTMF_ASSERT_NEXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid)
	`DTMF_ASSERT_NEXT(a_hold_data, m_tvalid && !m_tready, $stable(m_tdata))
	`DTMF_ASSERT_SAME(a_error_zero, m_tvalid && m_tuser, m_tdata == 64'd0)
	`DTMF_ASSERT_SAME(a_full_only, !s_tready, m_tvalid && !m_tready)

endmodule

bind double_to_minifloat_rounding_core dtmf_checker u_dtmf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
